// File: design/rmrq_pkg.sv
// shared types and constants of the rate-monotonic ready queue
package rmrq_pkg;

    localparam int unsigned PERIOD_W   = 32;
    localparam int unsigned TID_W      = 8;
    localparam int unsigned DEADLINE_W = 32;
    localparam int unsigned EXEC_W     = 31;
    localparam int unsigned DEPTH_W    = 5;
    localparam int unsigned S_TDATA_W  = 72;
    localparam int unsigned M_TDATA_W  = 48;

    localparam logic [PERIOD_W-1:0] RESET_PERIOD = 32'd1000;

    typedef enum logic {
        ACT_ENQUEUE  = 1'b0,
        ACT_DISPATCH = 1'b1
    } rmrq_action_t;

    // one shift command broadcast along the row of cells
    typedef struct packed {
        logic push;
        logic pop;
    } rmrq_cmd_t;

endpackage

// File: design/rate_monotonic_ready_queue_top.sv
// top level of the rate-monotonic ready queue
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | tdata task, deadline, exec; tuser action
//  m_      | out       | m_tvalid/m_tready  | tdata granted, id, period, dropped, depth
//  cfg_    | in        | cfg_valid/cfg_ready| default period
//
// one item a cycle unless the output stalls: each transfer shifts the whole
// row of cells at once and the result is loaded into the output register at
// the same edge and shows in the cycle after the input transfer
// a held output stalls the input only when the output register is not taken
// synchronous active-low reset empties the queue and restores the default period
module rate_monotonic_ready_queue_top import rmrq_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH  = 16,
    parameter int unsigned TASK_ID_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // task_id[7:0], deadline_ms[39:8], exec_time_ms[70:40], zero fill [71]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action[0]
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // granted[0], out_task_id[8:1], out_period[40:9], dropped_full[41],
    // depth_after[46:42], zero fill [47]
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [PERIOD_W-1:0]  cfg_data
);

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    logic [PERIOD_W-1:0] default_period_reg;

    logic                    m_tvalid_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;

    logic                    accept;
    rmrq_action_t            action;
    logic [TID_W-1:0]        in_task;
    logic [DEADLINE_W-1:0]   in_deadline;
    logic [EXEC_W-1:0]       in_exec;
    logic [PERIOD_W-1:0]     period;
    logic [TASK_ID_BITS-1:0] stored_task;
    logic [TASK_ID_BITS+TID_W-1:0] in_task_ext, head_task_ext, new_task_ext;
    logic [PERIOD_W-1:0]     head_period;
    logic [TASK_ID_BITS-1:0] head_task;
    logic [CW-1:0]           count, depth;
    logic [CW+DEPTH_W-1:0]   depth_ext;
    logic                    full, empty;
    rmrq_cmd_t               cmd;

    logic                    granted, dropped;
    logic [TID_W-1:0]        out_task;
    logic [PERIOD_W-1:0]     out_period;

    assign action      = rmrq_action_t'(s_tuser);
    assign in_task     = s_tdata[7:0];
    assign in_deadline = s_tdata[39:8];
    assign in_exec     = s_tdata[70:40];

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        if (in_deadline != '0) begin
            period = in_deadline;
        end else if (in_exec != '0) begin
            period = {in_exec, 1'b0};   // twice the execution time
        end else begin
            period = default_period_reg;
        end
    end

    // id is held in TASK_ID_BITS bits inside the cells
    assign in_task_ext   = {{TASK_ID_BITS{1'b0}}, in_task};
    assign stored_task   = in_task_ext[TASK_ID_BITS-1:0];
    assign new_task_ext  = {{TID_W{1'b0}}, stored_task};
    assign head_task_ext = {{TID_W{1'b0}}, head_task};

    assign full  = (count == CW'(QUEUE_DEPTH));
    assign empty = (count == '0);

    assign cmd.push = accept && (action == ACT_ENQUEUE) && !full;
    assign cmd.pop  = accept && (action == ACT_DISPATCH) && !empty;

    rmrq_chain #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .TASK_ID_BITS (TASK_ID_BITS)
    ) u_chain (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .new_period  (period),
        .new_task    (stored_task),
        .head_period (head_period),
        .head_task   (head_task),
        .count       (count)
    );

    always_comb begin
        depth = count;
        if (cmd.push) begin
            depth = count + 1'b1;
        end else if (cmd.pop) begin
            depth = count - 1'b1;
        end
    end
    assign depth_ext = {{DEPTH_W{1'b0}}, depth};

    always_comb begin
        granted    = 1'b0;
        dropped    = 1'b0;
        out_task   = '0;
        out_period = '0;
        unique case (action)
            ACT_ENQUEUE: begin
                granted    = !full;
                dropped    = full;
                out_task   = new_task_ext[TID_W-1:0];
                out_period = period;
            end
            ACT_DISPATCH: begin
                if (!empty) begin
                    granted    = 1'b1;
                    out_task   = head_task_ext[TID_W-1:0];
                    out_period = head_period;
                end
            end
            default: begin
                granted = 1'b0;
            end
        endcase
        m_tdata_next = {1'b0, depth_ext[DEPTH_W-1:0], dropped, out_period, out_task, granted};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg       <= 1'b0;
            default_period_reg <= RESET_PERIOD;
        end else begin
            if (accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                default_period_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: design/rmrq_cell.sv
// one slot of the sorted queue: holds a period and a task id
module rmrq_cell import rmrq_pkg::*; #(
    parameter int unsigned TASK_ID_BITS = 8
) (
    input  logic                          aclk,
    input  rmrq_cmd_t                     cmd,
    input  logic                          occupied,
    input  logic [PERIOD_W-1:0]           new_period,
    input  logic [TASK_ID_BITS-1:0]       new_task,
    input  logic                          left_keep,
    input  logic [PERIOD_W-1:0]           left_period,
    input  logic [TASK_ID_BITS-1:0]       left_task,
    input  logic [PERIOD_W-1:0]           right_period,
    input  logic [TASK_ID_BITS-1:0]       right_task,
    output logic                          keep,
    output logic [PERIOD_W-1:0]           period,
    output logic [TASK_ID_BITS-1:0]       task_id
);

    logic [PERIOD_W-1:0]     period_reg, period_next;
    logic [TASK_ID_BITS-1:0] task_reg, task_next;

    // equal periods stay ahead of the newcomer
    assign keep = occupied && (period_reg <= new_period);

    always_comb begin
        period_next = period_reg;
        task_next   = task_reg;
        if (cmd.push && !keep) begin
            if (left_keep) begin
                period_next = new_period;
                task_next   = new_task;
            end else begin
                period_next = left_period;
                task_next   = left_task;
            end
        end else if (cmd.pop) begin
            period_next = right_period;
            task_next   = right_task;
        end
    end

    always_ff @(posedge aclk) begin
        period_reg <= period_next;
        task_reg   <= task_next;
    end

    assign period  = period_reg;
    assign task_id = task_reg;

endmodule

// File: design/rmrq_chain.sv
// row of queue cells with the fill count
module rmrq_chain import rmrq_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH  = 16,
    parameter int unsigned TASK_ID_BITS = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  rmrq_cmd_t                            cmd,
    input  logic [PERIOD_W-1:0]                  new_period,
    input  logic [TASK_ID_BITS-1:0]              new_task,
    output logic [PERIOD_W-1:0]                  head_period,
    output logic [TASK_ID_BITS-1:0]              head_task,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]     count
);

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0] count_reg, count_next;

    logic                    keep   [QUEUE_DEPTH];
    logic [PERIOD_W-1:0]     per    [QUEUE_DEPTH];
    logic [TASK_ID_BITS-1:0] tsk    [QUEUE_DEPTH];

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic                    l_keep;
        logic [PERIOD_W-1:0]     l_per, r_per;
        logic [TASK_ID_BITS-1:0] l_tsk, r_tsk;

        if (i == 0) begin : g_head
            assign l_keep = 1'b0;
            assign l_per  = new_period;
            assign l_tsk  = new_task;
        end else begin : g_body
            assign l_keep = keep[i-1];
            assign l_per  = per[i-1];
            assign l_tsk  = tsk[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign r_per = per[i];
            assign r_tsk = tsk[i];
        end else begin : g_mid
            assign r_per = per[i+1];
            assign r_tsk = tsk[i+1];
        end

        rmrq_cell #(.TASK_ID_BITS(TASK_ID_BITS)) u_cell (
            .aclk         (aclk),
            .cmd          (cmd),
            .occupied     (count_reg > CW'(i)),
            .new_period   (new_period),
            .new_task     (new_task),
            .left_keep    (l_keep),
            .left_period  (l_per),
            .left_task    (l_tsk),
            .right_period (r_per),
            .right_task   (r_tsk),
            .keep         (keep[i]),
            .period       (per[i]),
            .task_id      (tsk[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.push) begin
            count_next = count_reg + 1'b1;
        end else if (cmd.pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign head_period = per[0];
    assign head_task   = tsk[0];
    assign count       = count_reg;

endmodule

// File: design/rmrq_checker.sv
// port-level checks of the ready queue, bound to the top level
module rmrq_checker import rmrq_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    localparam logic [DEPTH_W-1:0] FULL_DEPTH = DEPTH_W'(QUEUE_DEPTH);

    // a stalled result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // every input transfer shows a result in the next cycle
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("input transfer without result");

    // stored and refused never together
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[41]))
        else $error("granted and dropped_full both set");

    // a refusal only happens on a full queue
    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[41] |-> m_tdata[46:42] == FULL_DEPTH)
        else $error("dropped with queue not full");

    // dispatch from an empty queue gives an all-zero result
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] && !m_tdata[41] |-> m_tdata[46:1] == '0)
        else $error("empty dispatch with nonzero fields");

endmodule

bind rate_monotonic_ready_queue_top rmrq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_rmrq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: dv/tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the rate-monotonic ready queue
module tb;
    import rmrq_pkg::*;

    localparam int unsigned QUEUE_DEPTH  = 16;
    localparam int unsigned TASK_ID_BITS = 8;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned SEGMENTS     = 10;
    localparam int unsigned SEG_ITEMS    = 100;
    localparam logic [TID_W-1:0] TID_MASK = TID_W'((1 << TASK_ID_BITS) - 1);

    typedef struct {
        logic [PERIOD_W-1:0] period;
        logic [TID_W-1:0]    tid;
    } ready_slot_t;

    typedef struct {
        logic                granted;
        logic [TID_W-1:0]    tid;
        logic [PERIOD_W-1:0] period;
        logic                dropped;
        logic [DEPTH_W-1:0]  depth;
    } grant_result_t;

    // shadow of the sorted store plus the results still owed by the block
    class ready_queue_checker;
        logic [PERIOD_W-1:0] default_period;
        ready_slot_t         ready_tasks[$];
        grant_result_t       owed_results[$];
        int unsigned         errors, checked, enqueues, dispatches, drops, empties, period_writes;

        function new();
            default_period = RESET_PERIOD;
            errors = 0;
            checked = 0;
            enqueues = 0;
            dispatches = 0;
            drops = 0;
            empties = 0;
            period_writes = 0;
        endfunction

        function void set_default_period(logic [PERIOD_W-1:0] value);
            default_period = value;
            period_writes++;
        endfunction

        function int unsigned pending();
            return owed_results.size();
        endfunction

        function void note_item(rmrq_action_t action, logic [TID_W-1:0] tid,
                                logic [DEADLINE_W-1:0] deadline, logic [EXEC_W-1:0] exec);
            grant_result_t res;
            ready_slot_t   entry;
            int            pos;
            res.granted = 1'b0;
            res.tid     = '0;
            res.period  = '0;
            res.dropped = 1'b0;
            if (action == ACT_ENQUEUE) begin
                enqueues++;
                entry.tid = tid & TID_MASK;
                if (deadline != '0)
                    entry.period = deadline;
                else if (exec != '0)
                    entry.period = {exec, 1'b0};
                else
                    entry.period = default_period;
                res.tid    = entry.tid;
                res.period = entry.period;
                if (ready_tasks.size() >= QUEUE_DEPTH) begin
                    res.dropped = 1'b1;
                    drops++;
                end else begin
                    // behind every task with a shorter or equal period
                    pos = 0;
                    while (pos < ready_tasks.size() && ready_tasks[pos].period <= entry.period)
                        pos++;
                    ready_tasks.insert(pos, entry);
                    res.granted = 1'b1;
                end
            end else begin
                dispatches++;
                if (ready_tasks.size() > 0) begin
                    entry       = ready_tasks.pop_front();
                    res.granted = 1'b1;
                    res.tid     = entry.tid;
                    res.period  = entry.period;
                end else begin
                    empties++;
                end
            end
            res.depth = DEPTH_W'(ready_tasks.size());
            owed_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            grant_result_t want;
            if (owed_results.size() == 0) begin
                $error("result transfer with no expectation waiting: 0x%0h", data);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            checked++;
            compare_field("granted", 32'(want.granted), 32'(data[0]));
            compare_field("out_task_id", 32'(want.tid), 32'(data[8:1]));
            compare_field("out_period", want.period, data[40:9]);
            compare_field("dropped_full", 32'(want.dropped), 32'(data[41]));
            compare_field("depth_after", 32'(want.depth), 32'(data[46:42]));
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [PERIOD_W-1:0]  cfg_data;

    bit                   gaps_on;
    int unsigned          cycle_count;
    ready_queue_checker   checker_h;

    rate_monotonic_ready_queue_top #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TASK_ID_BITS(TASK_ID_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= !gaps_on || ($urandom_range(99) >= 29);
    end

    // watch every transfer on all three channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                checker_h.check_result(m_tdata);
            if (s_tvalid && s_tready)
                checker_h.note_item(rmrq_action_t'(s_tuser), s_tdata[7:0], s_tdata[39:8],
                                    s_tdata[70:40]);
            if (cfg_valid && cfg_ready)
                checker_h.set_default_period(cfg_data);
        end
    end

    task automatic send_item(rmrq_action_t action, logic [TID_W-1:0] tid,
                             logic [DEADLINE_W-1:0] deadline, logic [EXEC_W-1:0] exec);
        while (gaps_on && $urandom_range(99) < 29) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, exec, deadline, tid};
        s_tuser  <= action;
        do @(posedge aclk); while (!s_tready);
    endtask

    // sender holds off until every owed result has been taken
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (checker_h.pending() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_default_period(logic [PERIOD_W-1:0] value);
        wait_quiet();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic enqueue(logic [TID_W-1:0] tid, logic [DEADLINE_W-1:0] deadline,
                           logic [EXEC_W-1:0] exec);
        send_item(ACT_ENQUEUE, tid, deadline, exec);
    endtask

    // dispatch ignores the task fields, so they carry junk
    task automatic dispatch();
        send_item(ACT_DISPATCH, TID_W'($urandom), $urandom, EXEC_W'($urandom));
    endtask

    task automatic random_item(int unsigned enq_pct);
        logic [DEADLINE_W-1:0] deadline;
        logic [EXEC_W-1:0]     exec;
        deadline = $urandom;
        exec     = EXEC_W'($urandom);
        case ($urandom_range(9))
            0, 1, 2: begin
                deadline = '0;
                exec     = '0;
            end
            3: begin
                deadline = '0;
                exec     = EXEC_W'($urandom_range(1, 8));
            end
            4: deadline = '0;
            5, 6, 7: deadline = $urandom_range(1, 16);
            default: ;
        endcase
        if ($urandom_range(99) < enq_pct)
            enqueue(TID_W'($urandom), deadline, exec);
        else
            dispatch();
    endtask

    int unsigned enq_mix [SEGMENTS] = '{50, 85, 20, 65, 95, 10, 55, 45, 75, 35};

    initial begin
        checker_h   = new();
        cycle_count = 0;
        gaps_on     = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = ACT_ENQUEUE;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        gaps_on = 1'b1;

        // empty queue, then field extremes and equal-period ties
        dispatch();
        enqueue(8'h00, '0, '0);
        enqueue(8'hFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        enqueue(8'hA5, '0, 31'h7FFF_FFFF);
        enqueue(8'h5A, '0, 31'd1);
        enqueue(8'h07, 32'd1000, '0);
        enqueue(8'h08, '0, 31'd500);
        enqueue(8'h01, 32'd1, '0);
        for (int i = 0; i < 9; i++)
            enqueue(TID_W'(8'h10 + i), $urandom_range(1, 2000), EXEC_W'($urandom));
        // store is full here
        enqueue(8'hC3, 32'd5, '0);
        dispatch();
        dispatch();

        write_default_period('0);
        enqueue(8'h3C, '0, '0);
        dispatch();
        write_default_period(32'hFFFF_FFFF);
        enqueue(8'hC0, '0, '0);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                2: write_default_period(32'd1);
                4: write_default_period($urandom);
                6: write_default_period('0);
                8: write_default_period(RESET_PERIOD);
                default: ;
            endcase
            // one stretch runs flat out on both sides
            gaps_on = (seg != 3);
            for (int n = 0; n < SEG_ITEMS; n++)
                random_item(enq_mix[seg]);
        end
        gaps_on = 1'b1;

        // let the last input transfer be noted before counting what is owed
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (checker_h.pending() != 0);
        repeat (8) @(posedge aclk);

        $display("covered %0d enqueues (%0d refused on a full queue) and %0d dispatches (%0d empty)",
                 checker_h.enqueues, checker_h.drops, checker_h.dispatches, checker_h.empties);
        $display("%0d results checked across %0d default period settings",
                 checker_h.checked, checker_h.period_writes + 1);
        if (checker_h.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// File: files.f
design/rmrq_pkg.sv
design/rmrq_cell.sv
design/rmrq_chain.sv
design/rate_monotonic_ready_queue_top.sv
design/rmrq_checker.sv
dv/tb.sv
